// File: sv/ggc_pkg.sv
// ----------------------------------------------------------------------------
// ggc_pkg
// Shared types and constants of the greedy graph coloring core.
// ----------------------------------------------------------------------------
`default_nettype none

package ggc_pkg;

	localparam int VC_W    = 7;   // vertex count register
	localparam int IDX_W   = 6;   // vertex index field
	localparam int ROW_W   = 64;  // adjacency row field
	localparam int COLOR_W = 6;   // color field
	localparam int DEG_W   = 6;   // degree field

	localparam logic [VC_W-1:0] VC_RESET = 7'd64;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_START = 1'b1;

	// sequencer controls for the scan unit
	typedef struct packed {
		logic clear;   // new run: clear mask, degree and maximum
		logic acc;     // fold one row read into mask and degree
		logic commit;  // end of column: update maximum, restart mask and degree
	} ggc_scan_ctl_t;

endpackage

`default_nettype wire

// File: sv/ggc_chan_if.sv
// ----------------------------------------------------------------------------
// ggc_req_if / ggc_res_if
// Valid/ready channels for requests into and results out of the core.
// ----------------------------------------------------------------------------
`default_nettype none

interface ggc_req_if
	import ggc_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [IDX_W-1:0]  row_index;
	logic [ROW_W-1:0]  row_bits;

	modport source (output valid, output kind, output row_index, output row_bits,
		input ready);
	modport sink (input valid, input kind, input row_index, input row_bits,
		output ready);
endinterface

interface ggc_res_if
	import ggc_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   vertex;
	logic [COLOR_W-1:0] vertex_color;
	logic [DEG_W-1:0]   max_degree;
	logic               is_last;

	modport source (output valid, output vertex, output vertex_color,
		output max_degree, output is_last, input ready);
	modport sink (input valid, input vertex, input vertex_color,
		input max_degree, input is_last, output ready);
endinterface

`default_nettype wire

// File: sv/greedy_graph_coloring_core.sv
// Load request: writes one row. Start request: each of n vertices sweeps the
// row store (n reads, one per cycle), then drain and commit; then one result
// per vertex via the ORD and OLD states, held while the sink is busy.
// One request at a time; the read port of the row store sets the pace.
// Reset clears the sequencer, scan registers and output valid, and sets the
// vertex count to 64; the row and color stores are not cleared.
// ----------------------------------------------------------------------------
// greedy_graph_coloring_core
// First-fit greedy coloring with maximum degree over a loaded adjacency matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_graph_coloring_core
	import ggc_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cfg_we,
	input  wire  [VC_W-1:0] cfg_wdata,
	ggc_req_if.sink         req,
	ggc_res_if.source       res
);

	localparam int AW = $clog2(MAX_VERTICES);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DRAIN  = 3'd2;
	localparam logic [2:0] S_COMMIT = 3'd3;
	localparam logic [2:0] S_ORD    = 3'd4;
	localparam logic [2:0] S_OLD    = 3'd5;

	logic [2:0]         state_q;
	logic [VC_W-1:0]    vertex_count_q;
	logic [AW-1:0]      last_q;
	logic [AW-1:0]      u_q;
	logic [AW-1:0]      v_q;
	logic [AW-1:0]      o_v_q;
	logic               rd_valid_s1;
	logic [AW-1:0]      rd_u_s1;

	logic               res_valid_q;
	logic [IDX_W-1:0]   res_vertex_q;
	logic [COLOR_W-1:0] res_color_q;
	logic [DEG_W-1:0]   res_maxd_q;
	logic               res_last_q;

	logic                    req_fire;
	logic                    res_fire;
	logic [VC_W-1:0]         eff_count;
	logic [AW-1:0]           rd_addr;
	logic [MAX_VERTICES-1:0] row_rd;
	logic [COLOR_W-1:0]      color_rd;
	logic [COLOR_W-1:0]      new_color;
	logic [DEG_W-1:0]        max_degree;
	logic                    row_we;
	ggc_scan_ctl_t           scan_ctl;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign res_fire  = res_valid_q && res.ready;

	// zero counts as one, above the store depth saturates
	always_comb begin
		if (vertex_count_q == '0) begin
			eff_count = VC_W'(1);
		end else if (vertex_count_q > VC_W'(MAX_VERTICES)) begin
			eff_count = VC_W'(MAX_VERTICES);
		end else begin
			eff_count = vertex_count_q;
		end
	end

	assign row_we  = req_fire && (req.kind == KIND_LOAD)
		&& ({1'b0, req.row_index} < VC_W'(MAX_VERTICES));
	assign rd_addr = (state_q == S_SCAN) ? u_q : o_v_q;

	assign scan_ctl.clear  = req_fire && (req.kind == KIND_START);
	assign scan_ctl.acc    = rd_valid_s1;
	assign scan_ctl.commit = (state_q == S_COMMIT);

	ggc_mem #(
		.DEPTH (MAX_VERTICES),
		.AW    (AW)
	) u_mem (
		.clk         (clk),
		.row_we      (row_we),
		.row_waddr   (req.row_index[AW-1:0]),
		.row_wdata   (req.row_bits[MAX_VERTICES-1:0]),
		.color_we    (state_q == S_COMMIT),
		.color_waddr (v_q),
		.color_wdata (new_color),
		.rd_addr     (rd_addr),
		.row_rd_q    (row_rd),
		.color_rd_q  (color_rd)
	);

	ggc_scan_unit #(
		.NV (MAX_VERTICES),
		.AW (AW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.row        (row_rd),
		.color_rd   (color_rd),
		.u          (rd_u_s1),
		.v          (v_q),
		.new_color  (new_color),
		.max_degree (max_degree)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VC_RESET;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	// read tag travels with the registered memory data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		rd_u_s1 <= u_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= '0;
			u_q     <= '0;
			v_q     <= '0;
			o_v_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire && (req.kind == KIND_START)) begin
						last_q  <= AW'(eff_count - 1'b1);
						u_q     <= '0;
						v_q     <= '0;
						o_v_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					u_q <= u_q + 1'b1;
					if (u_q == last_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					u_q <= '0;
					if (v_q == last_q) begin
						state_q <= S_ORD;
					end else begin
						v_q     <= v_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_ORD: begin
					if (!res_valid_q || res.ready) begin
						state_q <= S_OLD;
					end
				end
				S_OLD: begin
					if (o_v_q == last_q) begin
						state_q <= S_IDLE;
					end else begin
						o_v_q   <= o_v_q + 1'b1;
						state_q <= S_ORD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_OLD) begin
			res_valid_q <= 1'b1;
		end else if (res_fire) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OLD) begin
			res_vertex_q <= IDX_W'(o_v_q);
			res_color_q  <= color_rd;
			res_maxd_q   <= max_degree;
			res_last_q   <= (o_v_q == last_q);
		end
	end

	assign res.valid        = res_valid_q;
	assign res.vertex       = res_vertex_q;
	assign res.vertex_color = res_color_q;
	assign res.max_degree   = res_maxd_q;
	assign res.is_last      = res_last_q;

	a_res_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == S_OLD)
		else $error("result raised outside the load step");

	a_start_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.kind == KIND_START) |=> state_q == S_SCAN)
		else $error("start request did not begin a scan");

	a_tag_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> rd_u_s1 <= last_q)
		else $error("row read beyond the vertex count");

	a_color_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMMIT |-> new_color <= COLOR_W'(v_q))
		else $error("color exceeds vertex index");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OLD) |-> (!res_valid_q || $past(res_fire)))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: sv/ggc_mem.sv
// ----------------------------------------------------------------------------
// ggc_mem
// Adjacency row store and vertex color store, one shared registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ggc_mem
	import ggc_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire                      clk,
	input  wire                      row_we,
	input  wire  [AW-1:0]            row_waddr,
	input  wire  [DEPTH-1:0]         row_wdata,
	input  wire                      color_we,
	input  wire  [AW-1:0]            color_waddr,
	input  wire  [COLOR_W-1:0]       color_wdata,
	input  wire  [AW-1:0]            rd_addr,
	output logic [DEPTH-1:0]         row_rd_q,
	output logic [COLOR_W-1:0]       color_rd_q
);

	logic [DEPTH-1:0]   rows_q   [DEPTH];
	logic [COLOR_W-1:0] colors_q [DEPTH];

	always_ff @(posedge clk) begin
		if (row_we) begin
			rows_q[row_waddr] <= row_wdata;
		end
		row_rd_q <= rows_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (color_we) begin
			colors_q[color_waddr] <= color_wdata;
		end
		color_rd_q <= colors_q[rd_addr];
	end

endmodule

`default_nettype wire

// File: sv/ggc_scan_unit.sv
// ----------------------------------------------------------------------------
// ggc_scan_unit
// Shared scan datapath: per row read, folds earlier neighbor colors into the
// used mask and counts the column degree; picks the first free color at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module ggc_scan_unit
	import ggc_pkg::*;
#(
	parameter int NV = 64,
	parameter int AW = 6
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  ggc_scan_ctl_t            ctl,
	input  wire  [NV-1:0]            row,
	input  wire  [COLOR_W-1:0]       color_rd,
	input  wire  [AW-1:0]            u,
	input  wire  [AW-1:0]            v,
	output logic [COLOR_W-1:0]       new_color,
	output logic [DEG_W-1:0]         max_degree
);

	logic [NV-1:0]    mask_q;
	logic [DEG_W-1:0] deg_q;
	logic [DEG_W-1:0] maxd_q;
	logic             edge_hit;

	assign edge_hit = row[v];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			deg_q  <= '0;
			maxd_q <= '0;
		end else if (ctl.clear) begin
			mask_q <= '0;
			deg_q  <= '0;
			maxd_q <= '0;
		end else if (ctl.commit) begin
			mask_q <= '0;
			deg_q  <= '0;
			if (deg_q > maxd_q) begin
				maxd_q <= deg_q;
			end
		end else if (ctl.acc && edge_hit) begin
			if (u != v) begin
				deg_q <= deg_q + 1'b1;
			end
			// only earlier vertices constrain the color
			if (u < v) begin
				mask_q <= mask_q | (NV'(1) << color_rd[AW-1:0]);
			end
		end
	end

	// first clear bit; all lower colors taken means the top color
	always_comb begin
		new_color = COLOR_W'(NV - 1);
		for (int i = NV - 2; i >= 0; i--) begin
			if (!mask_q[i]) begin
				new_color = COLOR_W'(i);
			end
		end
	end

	assign max_degree = maxd_q;

endmodule

`default_nettype wire

// File: tb/sv/coloring_checker.sv
// ----------------------------------------------------------------------------
// coloring_checker
// Watches the request and result channels of the coloring core. Keeps its own
// copy of the adjacency rows and vertex count, works out the colors and the
// maximum degree of each run on the start request, and compares every result
// field against the oldest color still due.
// ----------------------------------------------------------------------------
module coloring_checker
	import ggc_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cfg_we,
	input  wire  [VC_W-1:0] cfg_wdata,
	ggc_req_if              req,
	ggc_res_if              res,
	output int              fail_count,
	output int              pending
);

	typedef struct packed {
		logic [IDX_W-1:0]   vertex;
		logic [COLOR_W-1:0] vertex_color;
		logic [DEG_W-1:0]   max_degree;
		logic               is_last;
	} coloring_t;

	logic [ROW_W-1:0] adjacency [MAX_VERTICES];
	logic [VC_W-1:0]  vertex_count;
	coloring_t        colorings_due [$];
	int               nfail = 0;

	// first-fit coloring in vertex order; earlier neighbors are read by column
	task automatic predict_coloring();
		int unsigned        n, u, v, cnt, maxd, c;
		logic [ROW_W-1:0]   mask;
		logic [COLOR_W-1:0] color [MAX_VERTICES];
		coloring_t          item;
		n = (vertex_count == 0) ? 1 :
			((vertex_count > MAX_VERTICES) ? MAX_VERTICES : vertex_count);
		maxd = 0;
		for (v = 0; v < n; v++) begin
			cnt = 0;
			for (u = 0; u < n; u++)
				if (u != v && adjacency[u][v])
					cnt++;
			if (cnt > maxd)
				maxd = cnt;
		end
		color[0] = '0;
		for (v = 1; v < n; v++) begin
			mask = '0;
			for (u = 0; u < v; u++)
				if (adjacency[u][v])
					mask[color[u]] = 1'b1;
			c = 0;
			while (c < 63 && mask[c])
				c++;
			color[v] = COLOR_W'(c);
		end
		for (v = 0; v < n; v++) begin
			item.vertex       = IDX_W'(v);
			item.vertex_color = color[v];
			item.max_degree   = DEG_W'(maxd);
			item.is_last      = (v + 1 == n);
			colorings_due.push_back(item);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got, input logic [IDX_W-1:0] vtx);
		if (got !== want) begin
			nfail++;
			$display("%0t: vertex %0d %s mismatch: expected %0d, got %0d",
				$time, vtx, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		coloring_t got, want;
		if (!arst_n) begin
			vertex_count = VC_RESET;
			colorings_due.delete();
		end else begin
			if (cfg_we)
				vertex_count = cfg_wdata;
			if (req.valid && req.ready) begin
				if (req.kind == KIND_LOAD) begin
					if (req.row_index < MAX_VERTICES)
						adjacency[req.row_index] = req.row_bits;
				end else begin
					predict_coloring();
				end
			end
			if (res.valid && res.ready) begin
				got = '{res.vertex, res.vertex_color, res.max_degree, res.is_last};
				if (colorings_due.size() == 0) begin
					nfail++;
					$display("%0t: unexpected result: expected none, got vertex %0d color %0d",
						$time, got.vertex, got.vertex_color);
				end else begin
					want = colorings_due.pop_front();
					check_field("vertex", 8'(want.vertex), 8'(got.vertex), want.vertex);
					check_field("color", 8'(want.vertex_color), 8'(got.vertex_color),
						want.vertex);
					check_field("max_degree", 8'(want.max_degree), 8'(got.max_degree),
						want.vertex);
					check_field("is_last", 8'(want.is_last), 8'(got.is_last), want.vertex);
				end
			end
		end
		fail_count <= nfail;
		pending <= colorings_due.size();
	end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Regression for greedy_graph_coloring_core: directed small graphs and count
// edge cases, complete and random full-size matrices, then random graphs of
// mostly small size under changing sender and receiver idle rates.
// ----------------------------------------------------------------------------
module testbench
	import ggc_pkg::*;
	;

	localparam int MAX_V         = 64;
	localparam int ITEM_TARGET   = 400;
	localparam int CYCLE_LIMIT   = 10000000;
	localparam int SETTLE_CYCLES = 8;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            cfg_we;
	logic [VC_W-1:0] cfg_wdata;
	int              fail_count;
	int              pending;
	int              items_sent;
	int              idle_pct;
	int              stall_pct;
	int              cycle_count;
	int unsigned     row_order [MAX_V];

	ggc_req_if req_ch();
	ggc_res_if res_ch();

	greedy_graph_coloring_core #(.MAX_VERTICES(MAX_V)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.res       (res_ch)
	);

	coloring_checker #(.MAX_VERTICES(MAX_V)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req_ch),
		.res        (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_req(input logic kind, input logic [IDX_W-1:0] idx,
		input logic [ROW_W-1:0] bits);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.kind      <= kind;
		req_ch.row_index <= idx;
		req_ch.row_bits  <= bits;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	// start request; the unused payload is random
	task automatic start_run();
		send_req(KIND_START, IDX_W'($urandom), {$urandom, $urandom});
	endtask

	task automatic wait_until_colored();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [VC_W-1:0] value);
		wait_until_colored();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic shuffle_rows(input int unsigned n);
		int unsigned i, j, tmp;
		for (i = 0; i < n; i++)
			row_order[i] = i;
		for (i = n; i > 1; i--) begin
			j = $urandom_range(i - 1);
			tmp = row_order[i - 1];
			row_order[i - 1] = row_order[j];
			row_order[j] = tmp;
		end
	endtask

	function automatic logic [ROW_W-1:0] row_pattern();
		logic [ROW_W-1:0] a, b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(5))
			0: return a & b & {$urandom, $urandom};
			1: return a | b;
			2: return '0;
			3: return '1;
			default: return a;
		endcase
	endfunction

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("greedy_graph_coloring_core regression: fail");
		$finish;
	end

	initial begin : stimulus
		int unsigned graph_no, vcount, n, i, nloads, pick;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		req_ch.valid     = 1'b0;
		req_ch.kind      = KIND_LOAD;
		req_ch.row_index = '0;
		req_ch.row_bits  = '0;
		res_ch.ready     = 1'b0;
		idle_pct         = 0;
		stall_pct        = 0;
		items_sent       = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single vertex; a count of zero runs as one vertex
		write_vertex_count(VC_W'(1));
		send_req(KIND_LOAD, IDX_W'(0), '1);
		start_run();
		write_vertex_count(VC_W'(0));
		send_req(KIND_START, '1, '1);
		// row 0 still all ones: one edge 0->1 plus a self loop
		write_vertex_count(VC_W'(2));
		send_req(KIND_LOAD, IDX_W'(1), '0);
		send_req(KIND_START, '0, '0);
		// asymmetric rows, bits past the count set in row 2
		write_vertex_count(VC_W'(3));
		send_req(KIND_LOAD, IDX_W'(0), 64'h4);
		send_req(KIND_LOAD, IDX_W'(1), 64'h4);
		send_req(KIND_LOAD, IDX_W'(2), 64'hFFFF_FFFF_FFFF_FFF8);
		start_run();
		// complete graph on four vertices
		write_vertex_count(VC_W'(4));
		for (i = 0; i < 4; i++)
			send_req(KIND_LOAD, IDX_W'(i), '1);
		start_run();

		// complete graph on every vertex: all colors and the top degree
		write_vertex_count(VC_W'(MAX_V));
		shuffle_rows(MAX_V);
		for (i = 0; i < MAX_V; i++)
			send_req(KIND_LOAD, IDX_W'(row_order[i]), '1);
		start_run();
		// saturating count over a freshly loaded random matrix
		write_vertex_count('1);
		shuffle_rows(MAX_V);
		for (i = 0; i < MAX_V; i++)
			send_req(KIND_LOAD, IDX_W'(row_order[i]), row_pattern());
		start_run();

		// every row is loaded from here on, so any count is safe to run
		graph_no = 0;
		vcount = MAX_V;
		while (items_sent < ITEM_TARGET) begin
			case (graph_no % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 66;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 66;
				end
				default: begin
					idle_pct = 10;
					stall_pct = 10;
				end
			endcase
			if (graph_no % 3 == 0) begin
				pick = $urandom_range(99);
				if (pick < 70)
					vcount = $urandom_range(12, 1);
				else if (pick < 85)
					vcount = $urandom_range(40, 13);
				else if (pick < 95)
					vcount = $urandom_range(64, 41);
				else
					vcount = $urandom_range(1) ? 0 : $urandom_range(127, 65);
				write_vertex_count(VC_W'(vcount));
			end
			n = (vcount == 0) ? 1 : ((vcount > MAX_V) ? MAX_V : vcount);
			if ($urandom_range(99) < 85) begin
				// reload rows of the active graph, then color it
				shuffle_rows(n);
				nloads = (n <= 12) ? n : $urandom_range(8, 1);
				for (i = 0; i < nloads; i++)
					send_req(KIND_LOAD, IDX_W'(row_order[i]), row_pattern());
				start_run();
			end else begin
				// stray loads anywhere, sometimes with no run after them
				nloads = $urandom_range(4, 1);
				for (i = 0; i < nloads; i++)
					send_req(KIND_LOAD, IDX_W'($urandom), row_pattern());
				if ($urandom_range(1))
					start_run();
			end
			if ($urandom_range(99) < 10)
				wait_until_colored();
			graph_no++;
		end

		wait_until_colored();
		if (fail_count == 0 && pending == 0)
			$display("greedy_graph_coloring_core regression: pass");
		else
			$display("greedy_graph_coloring_core regression: fail");
		$finish;
	end

endmodule

// File: sim.f
sv/ggc_pkg.sv
sv/ggc_chan_if.sv
sv/ggc_mem.sv
sv/ggc_scan_unit.sv
sv/greedy_graph_coloring_core.sv
tb/sv/coloring_checker.sv
tb/sv/testbench.sv
